@@ hdl/ess_pkg.sv @@
// Package for the English suffix stemmer: character and window types, step codes,
// the suffix rule table and the command and status structs of the core.
// Depends on nothing.
package ess_pkg;

	localparam int ESS_MAX_WORD = 32;
	localparam int WIN = 8;
	localparam int NRULES = 54;

	typedef logic [7:0] char_t;
	typedef char_t [WIN-1:0] win_t;

	typedef enum logic [2:0] {C_NONE, C_R1, C_R2, C_OGI, C_LI, C_ION} cond_t;

	typedef enum logic [2:0] {
		STP_0, STP_1A, STP_1B, STP_1C, STP_2, STP_3, STP_4, STP_5
	} step_t;

	typedef struct packed {
		step_t       stp;
		logic [55:0] suf;
		logic [2:0]  sl;
		logic [31:0] rep;
		logic [2:0]  rl;
		cond_t       cond;
	} rule_t;

	typedef struct packed {
		logic  ld;
		logic  ev;
		logic  pop;
		logic  push;
		logic  align;
		logic  mark;
		logic  emit;
		step_t step;
	} cmd_t;

	typedef struct packed {
		logic short_word;
		logic pop_done;
		logic push_done;
		logic aligned;
		logic last;
	} stat_t;

	// Rules are listed longest suffix first within each step.
	localparam rule_t RULES [NRULES] = '{
		'{STP_0, "'s'", 3'd3, 32'd0, 3'd0, C_NONE},
		'{STP_0, "'s", 3'd2, 32'd0, 3'd0, C_NONE},
		'{STP_0, "'", 3'd1, 32'd0, 3'd0, C_NONE},
		'{STP_2, "ization", 3'd7, "ize", 3'd3, C_R1},
		'{STP_2, "ational", 3'd7, "ate", 3'd3, C_R1},
		'{STP_2, "fulness", 3'd7, "ful", 3'd3, C_R1},
		'{STP_2, "ousness", 3'd7, "ous", 3'd3, C_R1},
		'{STP_2, "iveness", 3'd7, "ive", 3'd3, C_R1},
		'{STP_2, "tional", 3'd6, "tion", 3'd4, C_R1},
		'{STP_2, "biliti", 3'd6, "ble", 3'd3, C_R1},
		'{STP_2, "lessli", 3'd6, "less", 3'd4, C_R1},
		'{STP_2, "entli", 3'd5, "ent", 3'd3, C_R1},
		'{STP_2, "ation", 3'd5, "ate", 3'd3, C_R1},
		'{STP_2, "alism", 3'd5, "al", 3'd2, C_R1},
		'{STP_2, "aliti", 3'd5, "al", 3'd2, C_R1},
		'{STP_2, "ousli", 3'd5, "ous", 3'd3, C_R1},
		'{STP_2, "iviti", 3'd5, "ive", 3'd3, C_R1},
		'{STP_2, "fulli", 3'd5, "ful", 3'd3, C_R1},
		'{STP_2, "enci", 3'd4, "ence", 3'd4, C_R1},
		'{STP_2, "anci", 3'd4, "ance", 3'd4, C_R1},
		'{STP_2, "abli", 3'd4, "able", 3'd4, C_R1},
		'{STP_2, "izer", 3'd4, "ize", 3'd3, C_R1},
		'{STP_2, "ator", 3'd4, "ate", 3'd3, C_R1},
		'{STP_2, "alli", 3'd4, "al", 3'd2, C_R1},
		'{STP_2, "bli", 3'd3, "ble", 3'd3, C_R1},
		'{STP_2, "ogi", 3'd3, "og", 3'd2, C_OGI},
		'{STP_2, "li", 3'd2, 32'd0, 3'd0, C_LI},
		'{STP_3, "ational", 3'd7, "ate", 3'd3, C_R1},
		'{STP_3, "tional", 3'd6, "tion", 3'd4, C_R1},
		'{STP_3, "alize", 3'd5, "al", 3'd2, C_R1},
		'{STP_3, "icate", 3'd5, "ic", 3'd2, C_R1},
		'{STP_3, "iciti", 3'd5, "ic", 3'd2, C_R1},
		'{STP_3, "ative", 3'd5, 32'd0, 3'd0, C_R2},
		'{STP_3, "ical", 3'd4, "ic", 3'd2, C_R1},
		'{STP_3, "ness", 3'd4, 32'd0, 3'd0, C_R1},
		'{STP_3, "ful", 3'd3, 32'd0, 3'd0, C_R1},
		'{STP_4, "ement", 3'd5, 32'd0, 3'd0, C_R2},
		'{STP_4, "ance", 3'd4, 32'd0, 3'd0, C_R2},
		'{STP_4, "ence", 3'd4, 32'd0, 3'd0, C_R2},
		'{STP_4, "able", 3'd4, 32'd0, 3'd0, C_R2},
		'{STP_4, "ible", 3'd4, 32'd0, 3'd0, C_R2},
		'{STP_4, "ment", 3'd4, 32'd0, 3'd0, C_R2},
		'{STP_4, "ant", 3'd3, 32'd0, 3'd0, C_R2},
		'{STP_4, "ent", 3'd3, 32'd0, 3'd0, C_R2},
		'{STP_4, "ism", 3'd3, 32'd0, 3'd0, C_R2},
		'{STP_4, "ate", 3'd3, 32'd0, 3'd0, C_R2},
		'{STP_4, "iti", 3'd3, 32'd0, 3'd0, C_R2},
		'{STP_4, "ous", 3'd3, 32'd0, 3'd0, C_R2},
		'{STP_4, "ive", 3'd3, 32'd0, 3'd0, C_R2},
		'{STP_4, "ize", 3'd3, 32'd0, 3'd0, C_R2},
		'{STP_4, "ion", 3'd3, 32'd0, 3'd0, C_ION},
		'{STP_4, "al", 3'd2, 32'd0, 3'd0, C_R2},
		'{STP_4, "er", 3'd2, 32'd0, 3'd0, C_R2},
		'{STP_4, "ic", 3'd2, 32'd0, 3'd0, C_R2}
	};

	function automatic logic is_aeiou(char_t c);
		return c == "a" || c == "e" || c == "i" || c == "o" || c == "u";
	endfunction

	function automatic logic valid_li(char_t c);
		return c == "c" || c == "d" || c == "e" || c == "g" || c == "h" ||
			c == "k" || c == "m" || c == "n" || c == "r" || c == "t";
	endfunction

	function automatic logic is_dbl(char_t c);
		return c == "b" || c == "d" || c == "f" || c == "g" || c == "m" ||
			c == "n" || c == "p" || c == "r" || c == "t";
	endfunction

	// Window entry 0 is the last character; byte 0 of the suffix is its last letter.
	function automatic logic suf_hit(win_t w, logic [55:0] s, logic [2:0] sl);
		logic hit;
		hit = 1'b1;
		for (int i = 0; i < 7; i++) begin
			if (3'(i) < sl && w[i] != s[8*i +: 8])
				hit = 1'b0;
		end
		return hit;
	endfunction

	function automatic step_t next_step(step_t s);
		step_t n;
		case (s)
			STP_0:   n = STP_1A;
			STP_1A:  n = STP_1B;
			STP_1B:  n = STP_1C;
			STP_1C:  n = STP_2;
			STP_2:   n = STP_3;
			STP_3:   n = STP_4;
			STP_4:   n = STP_5;
			default: n = STP_0;
		endcase
		return n;
	endfunction

endpackage

@@ hdl/ess_ifs.sv @@
// Handshake interfaces of the stemmer: the character input channel and the stem output
// channel, each with valid, ready and payload. Depends on nothing.
interface ess_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] letter;
	logic       word_end;
	modport source(output valid, letter, word_end, input ready);
	modport sink(input valid, letter, word_end, output ready);
endinterface

interface ess_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] stem_char;
	logic       stem_end;
	logic       overflow;
	modport source(output valid, stem_char, stem_end, overflow, input ready);
	modport sink(input valid, stem_char, stem_end, overflow, output ready);
endinterface

@@ hdl/ess_ctrl.sv @@
// Controller of the stemmer: state machine that sequences loading, the suffix steps,
// alignment and output. Depends on ess_pkg.
module ess_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          word_end,
	output logic          in_ready,
	input  logic          out_ready,
	output logic          out_valid,
	input  ess_pkg::stat_t stat,
	output ess_pkg::cmd_t  cmd
);
	import ess_pkg::*;

	typedef enum logic [5:0] {
		S_LOAD  = 6'b000001,
		S_EVAL  = 6'b000010,
		S_POP   = 6'b000100,
		S_PUSH  = 6'b001000,
		S_ALIGN = 6'b010000,
		S_EMIT  = 6'b100000
	} state_t;

	state_t state_q, state_nx;
	step_t  step_q;
	logic   ov_q;

	always_comb begin
		cmd = '0;
		cmd.step = step_q;
		state_nx = state_q;
		in_ready = (state_q == S_LOAD);
		case (state_q)
			S_LOAD: begin
				if (in_valid) begin
					cmd.ld = 1'b1;
					if (word_end)
						state_nx = S_EVAL;
				end
			end
			S_EVAL: begin
				if (step_q == STP_0 && stat.short_word) begin
					cmd.mark = 1'b1;
					state_nx = S_ALIGN;
				end else begin
					cmd.ev = 1'b1;
					state_nx = S_POP;
				end
			end
			S_POP: begin
				if (stat.pop_done)
					state_nx = S_PUSH;
				else
					cmd.pop = 1'b1;
			end
			S_PUSH: begin
				if (stat.push_done) begin
					if (step_q == STP_5) begin
						cmd.mark = 1'b1;
						state_nx = S_ALIGN;
					end else begin
						state_nx = S_EVAL;
					end
				end else begin
					cmd.push = 1'b1;
				end
			end
			S_ALIGN: begin
				if (stat.aligned)
					state_nx = S_EMIT;
				else
					cmd.align = 1'b1;
			end
			S_EMIT: begin
				if (!ov_q || out_ready) begin
					cmd.emit = 1'b1;
					if (stat.last)
						state_nx = S_LOAD;
				end
			end
			default: state_nx = S_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			step_q <= STP_0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.mark)
				step_q <= STP_0;
			else if (state_q == S_PUSH && stat.push_done)
				step_q <= next_step(step_q);
			if (cmd.emit)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
		end
	end

	assign out_valid = ov_q;

endmodule

@@ hdl/ess_datapath.sv @@
// Datapath of the stemmer: right-aligned character shift register with vowel flags,
// region tracking, suffix rule evaluation and the output register. Depends on ess_pkg.
module ess_datapath #(
	parameter int MAX_WORD = ess_pkg::ESS_MAX_WORD
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     letter,
	input  logic           word_end,
	input  ess_pkg::cmd_t  cmd,
	output ess_pkg::stat_t stat,
	output logic [7:0]     stem_char,
	output logic           stem_end,
	output logic           overflow
);
	import ess_pkg::*;

	localparam int LW = $clog2(MAX_WORD + 1);
	localparam logic [LW-1:0] FULL = LW'(MAX_WORD);

	char_t               chr_q [MAX_WORD];
	logic [MAX_WORD-1:0] vow_q;
	logic [LW-1:0]       len_q, r1_q, r2_q, fv_q, stem_q;
	logic                r1f_q, r2f_q, too_long_q;
	logic [2:0]          pop_q, rl_q, pidx_q;
	logic [31:0]         rep_q;
	char_t               out_char_q;
	logic                out_end_q, out_ovf_q;

	win_t           win;
	logic [WIN-1:0] vw;
	logic           room, shift_up, ins_v, nv, trans, r1_hit, r2_hit;
	char_t          ins_c;
	logic [1:0]     rsel;
	logic [LW-1:0]  len_nx;
	logic [2:0]     pl_pop, pl_rl;
	logic [31:0]    pl_rep;

	for (genvar gi = 0; gi < WIN; gi++) begin : g_win
		if (gi < MAX_WORD) begin : g_tap
			assign win[gi] = chr_q[gi];
			assign vw[gi] = vow_q[gi];
		end else begin : g_pad
			assign win[gi] = '0;
			assign vw[gi] = 1'b0;
		end
	end

	function automatic logic fits(logic [LW-1:0] n, logic [2:0] sl);
		return n >= LW'(sl);
	endfunction

	function automatic logic cond_ok(cond_t c, logic [LW-1:0] p, logic pnz, char_t prev,
		logic [LW-1:0] r1, logic [LW-1:0] r2);
		logic ok;
		case (c)
			C_R1:    ok = p >= r1;
			C_R2:    ok = p >= r2;
			C_OGI:   ok = p >= r1 && pnz && prev == "l";
			C_LI:    ok = p >= r1 && pnz && valid_li(prev);
			C_ION:   ok = p >= r2 && pnz && (prev == "s" || prev == "t");
			default: ok = 1'b1;
		endcase
		return ok;
	endfunction

	// Short syllable ending at window entry b, for a word of m characters.
	function automatic logic short_syl(win_t w, logic [WIN-1:0] v, logic [2:0] b,
		logic [LW-1:0] m);
		logic s;
		if (m == LW'(2))
			s = v[b + 3'd1] && !v[b];
		else if (m >= LW'(3))
			s = w[b] != "w" && w[b] != "x" && w[b] != "y" &&
				!v[b + 3'd2] && v[b + 3'd1] && !v[b];
		else
			s = 1'b0;
		return s;
	endfunction

	assign room = len_q < FULL;
	assign nv = is_aeiou(letter) || (letter == "y" && len_q != '0 && !vow_q[0]);
	assign trans = room && len_q != '0 && vow_q[0] && !nv;
	assign r1_hit = trans && !r1f_q;
	assign r2_hit = trans && r1f_q && !r2f_q && len_q > r1_q;
	assign len_nx = room ? len_q + LW'(1) : len_q;

	assign rsel = 2'(rl_q - 3'd1 - pidx_q);
	assign shift_up = (cmd.ld && room) || cmd.push || cmd.align || cmd.emit;

	always_comb begin
		if (cmd.ld)
			ins_c = letter;
		else if (cmd.push)
			ins_c = rep_q[{rsel, 3'b000} +: 8];
		else
			ins_c = '0;
		ins_v = is_aeiou(ins_c) || (ins_c == "y" && len_q != '0 && !vow_q[0]);
	end

	always_comb begin
		rule_t         r;
		logic          done, found;
		logic [LW-1:0] n, p;
		logic [2:0]    sl;
		pl_pop = '0;
		pl_rep = '0;
		pl_rl = '0;
		done = 1'b0;
		found = 1'b0;
		sl = '0;
		n = len_q;
		p = '0;
		for (int k = 0; k < NRULES; k++) begin
			r = RULES[k];
			if (!done && r.stp == cmd.step && fits(n, r.sl) && suf_hit(win, r.suf, r.sl))
			begin
				done = 1'b1;
				if (cond_ok(r.cond, n - LW'(r.sl), n > LW'(r.sl), win[r.sl], r1_q, r2_q))
				begin
					pl_pop = r.sl;
					pl_rep = r.rep;
					pl_rl = r.rl;
				end
			end
		end
		case (cmd.step)
			STP_1A: begin
				if (fits(n, 3'd4) && suf_hit(win, "sses", 3'd4)) begin
					pl_pop = 3'd2;
				end else if (fits(n, 3'd3) &&
					(suf_hit(win, "ied", 3'd3) || suf_hit(win, "ies", 3'd3))) begin
					pl_pop = (n > LW'(4)) ? 3'd2 : 3'd1;
				end else if (fits(n, 3'd2) &&
					(suf_hit(win, "ss", 3'd2) || suf_hit(win, "us", 3'd2))) begin
					pl_pop = '0;
				end else if (fits(n, 3'd1) && suf_hit(win, "s", 3'd1)) begin
					if (n >= LW'(2) && fv_q < n - LW'(2))
						pl_pop = 3'd1;
				end
			end
			STP_1B: begin
				if (fits(n, 3'd5) && suf_hit(win, "eedly", 3'd5)) begin
					sl = 3'd5;
					found = 1'b1;
				end else if (fits(n, 3'd3) && suf_hit(win, "eed", 3'd3)) begin
					sl = 3'd3;
					found = 1'b1;
				end
				if (found) begin
					p = n - LW'(sl);
					if (p >= r1_q)
						pl_pop = sl - 3'd2;
				end else begin
					if (fits(n, 3'd5) && suf_hit(win, "ingly", 3'd5)) begin
						sl = 3'd5;
						found = 1'b1;
					end else if (fits(n, 3'd4) && suf_hit(win, "edly", 3'd4)) begin
						sl = 3'd4;
						found = 1'b1;
					end else if (fits(n, 3'd3) && suf_hit(win, "ing", 3'd3)) begin
						sl = 3'd3;
						found = 1'b1;
					end else if (fits(n, 3'd2) && suf_hit(win, "ed", 3'd2)) begin
						sl = 3'd2;
						found = 1'b1;
					end
					if (found) begin
						p = n - LW'(sl);
						if (fv_q < p) begin
							pl_pop = sl;
							if (p >= LW'(2) &&
								((win[sl + 3'd1] == "a" && win[sl] == "t") ||
								(win[sl + 3'd1] == "b" && win[sl] == "l") ||
								(win[sl + 3'd1] == "i" && win[sl] == "z"))) begin
								pl_rep = 32'("e");
								pl_rl = 3'd1;
							end else if (p >= LW'(2) && win[sl] == win[sl + 3'd1] &&
								is_dbl(win[sl])) begin
								pl_pop = sl + 3'd1;
							end else if (short_syl(win, vw, sl, p) && r1_q >= p) begin
								pl_rep = 32'("e");
								pl_rl = 3'd1;
							end
						end
					end
				end
			end
			STP_1C: begin
				if (n >= LW'(3) && win[0] == "y" && !vw[1]) begin
					pl_pop = 3'd1;
					pl_rep = 32'("i");
					pl_rl = 3'd1;
				end
			end
			STP_5: begin
				if (n != '0) begin
					p = n - LW'(1);
					if (win[0] == "e") begin
						if (p >= r2_q || (p >= r1_q && !short_syl(win, vw, 3'd1, p)))
							pl_pop = 3'd1;
					end else if (win[0] == "l") begin
						if (p >= r2_q && n > LW'(1) && win[1] == "l")
							pl_pop = 3'd1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (shift_up) begin
			chr_q[0] <= ins_c;
			vow_q[0] <= ins_v;
			for (int i = 1; i < MAX_WORD; i++) begin
				chr_q[i] <= chr_q[i-1];
				vow_q[i] <= vow_q[i-1];
			end
		end else if (cmd.pop) begin
			for (int i = 0; i < MAX_WORD - 1; i++) begin
				chr_q[i] <= chr_q[i+1];
				vow_q[i] <= vow_q[i+1];
			end
		end
		if (cmd.ev) begin
			rep_q <= pl_rep;
			rl_q <= pl_rl;
		end
		if (cmd.emit) begin
			out_char_q <= (stem_q == '0) ? 8'h00 : chr_q[MAX_WORD-1];
			out_end_q <= stem_q <= LW'(1);
			out_ovf_q <= too_long_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			r1_q <= '0;
			r2_q <= '0;
			r1f_q <= 1'b0;
			r2f_q <= 1'b0;
			fv_q <= FULL;
			too_long_q <= 1'b0;
			stem_q <= '0;
			pop_q <= '0;
			pidx_q <= '0;
		end else if (cmd.ld) begin
			len_q <= len_nx;
			if (!room)
				too_long_q <= 1'b1;
			if (room && nv && fv_q == FULL)
				fv_q <= len_q;
			if (r1_hit) begin
				r1_q <= len_q + LW'(1);
				r1f_q <= 1'b1;
			end else if (word_end && !r1f_q) begin
				r1_q <= len_nx;
			end
			if (r2_hit) begin
				r2_q <= len_q + LW'(1);
				r2f_q <= 1'b1;
			end else if (word_end && !r2f_q) begin
				r2_q <= len_nx;
			end
		end else if (cmd.ev) begin
			pop_q <= pl_pop;
			pidx_q <= '0;
		end else if (cmd.pop) begin
			len_q <= len_q - LW'(1);
			pop_q <= pop_q - 3'd1;
		end else if (cmd.push) begin
			len_q <= len_q + LW'(1);
			pidx_q <= pidx_q + 3'd1;
		end else if (cmd.align) begin
			len_q <= len_q + LW'(1);
		end else if (cmd.mark) begin
			stem_q <= len_q;
		end else if (cmd.emit) begin
			if (stem_q <= LW'(1)) begin
				stem_q <= '0;
				len_q <= '0;
				r1_q <= '0;
				r2_q <= '0;
				r1f_q <= 1'b0;
				r2f_q <= 1'b0;
				fv_q <= FULL;
				too_long_q <= 1'b0;
			end else begin
				stem_q <= stem_q - LW'(1);
			end
		end
	end

	assign stat.short_word = len_q <= LW'(2);
	assign stat.pop_done = pop_q == '0;
	assign stat.push_done = pidx_q == rl_q;
	assign stat.aligned = len_q == FULL;
	assign stat.last = stem_q <= LW'(1);

	assign stem_char = out_char_q;
	assign stem_end = out_end_q;
	assign overflow = out_ovf_q;

endmodule

@@ hdl/english_suffix_stemmer_core.sv @@
// Top level of the English suffix stemmer. After the last character, each of the eight
// suffix steps evaluates its rules, removes characters one at a time and then appends
// the replacement ones; a word of two characters or fewer skips the steps after one
// evaluation. The stem is then shifted up until it fills the store, and leaves one
// character per cycle at the output while the output is ready. Words are handled one at
// a time. Reset clears all control state; the store needs none.
module english_suffix_stemmer_core #(
	parameter int MAX_WORD = ess_pkg::ESS_MAX_WORD
) (
	input logic clk,
	input logic arst_n,
	ess_in_if.sink    chars,
	ess_out_if.source stems
);
	import ess_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	ess_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chars.valid),
		.word_end  (chars.word_end),
		.in_ready  (chars.ready),
		.out_ready (stems.ready),
		.out_valid (stems.valid),
		.stat      (stat),
		.cmd       (cmd)
	);

	ess_datapath #(
		.MAX_WORD (MAX_WORD)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.letter    (chars.letter),
		.word_end  (chars.word_end),
		.cmd       (cmd),
		.stat      (stat),
		.stem_char (stems.stem_char),
		.stem_end  (stems.stem_end),
		.overflow  (stems.overflow)
	);

endmodule
